/* src/nkdt_pkg.sv */
// Shared types, constants and the name normalisation function of the directory table.
`timescale 1ns / 1ps
`default_nettype none

package nkdt_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int NAME_BYTES_DEF = 9;
    localparam int NAME_BYTES_MAX = 9;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int SECTOR_W = 10;
    localparam int KEY_W    = 8 * NAME_BYTES_MAX;

    // Input transfer: name head, name tail, sector, padded to whole bytes.
    localparam int IN_DATA_W  = ((KEY_W + SECTOR_W + 7) / 8) * 8;
    // Result transfer: entry index, sector, padded to whole bytes.
    localparam int OUT_DATA_W = ((INDEX_W + SECTOR_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } nkdt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } nkdt_stat_t;

    // Every byte from the first zero byte onwards, and beyond name_bytes, reads as zero.
    function automatic logic [KEY_W-1:0] normalize_key(input logic [63:0] head,
                                                       input logic [7:0] tail,
                                                       input int name_bytes);
        logic [KEY_W-1:0] raw;
        logic [KEY_W-1:0] key;
        logic             ended;
        raw   = {tail, head};
        key   = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_BYTES_MAX; i++)
        begin
            if (i >= name_bytes || raw[8*i +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
            key[8*i +: 8] = ended ? 8'h00 : raw[8*i +: 8];
        end
        return key;
    endfunction

endpackage

`default_nettype wire

/* src/name_keyed_directory_table_unit.sv */
// Top level of the name-keyed directory table: controller and datapath.
//
//  Channel | Direction | tdata (low bit up)                             | tuser
//  --------+-----------+------------------------------------------------+------------
//  s_axis  | in        | name_head[63:0] name_tail[71:64] sector_in[81:72] | mode[1:0]
//  m_axis  | out       | entry_index[3:0] sector_out[13:4]              | status[1:0]
//
// One request is handled at a time. The block latches each accepted request, then the
// single read port of the entry memory sweeps the table one entry per cycle, the
// compare stage takes the last entry, and a commit step updates the table and loads
// the result register; only after the commit does the block accept the next
// request.
// Reset clears every valid bit at once, so the table is empty and usable straight
// after reset; the key and sector memory is never cleared.
// A result waiting on m_axis does not stop the next request being accepted and
// swept; only its commit waits until the result register has been emptied.
`timescale 1ns / 1ps
`default_nettype none

module name_keyed_directory_table_unit #(
    parameter int TABLE_SIZE = nkdt_pkg::TABLE_SIZE_DEF,
    parameter int NAME_BYTES = nkdt_pkg::NAME_BYTES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // name_head[63:0], name_tail[71:64], sector_in[81:72], zero pad [87:82]
    input  wire [nkdt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode[1:0]
    input  wire [nkdt_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // entry_index[3:0], sector_out[13:4], zero pad [15:14]
    output logic [nkdt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [nkdt_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import nkdt_pkg::*;

    // Commands from the controller and status back from the datapath.
    nkdt_cmd_t  cmd;
    nkdt_stat_t stat;

    nkdt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    nkdt_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* src/nkdt_ctrl.sv */
// Controller state machine: accept, sweep the table, drain the compare stage, commit.
`timescale 1ns / 1ps
`default_nettype none

module nkdt_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  nkdt_pkg::nkdt_stat_t stat,
    output nkdt_pkg::nkdt_cmd_t  cmd
);
    import nkdt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Hold until the result register can take the answer.
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/nkdt_datapath.sv */
// Datapath: entry memory, valid bits, sweep counter, compare stage, result register.
`timescale 1ns / 1ps
`default_nettype none

module nkdt_datapath #(
    parameter int TABLE_SIZE = nkdt_pkg::TABLE_SIZE_DEF,
    parameter int NAME_BYTES = nkdt_pkg::NAME_BYTES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  nkdt_pkg::nkdt_cmd_t              cmd,
    output nkdt_pkg::nkdt_stat_t             stat,
    input  wire [nkdt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire [nkdt_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [nkdt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [nkdt_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import nkdt_pkg::*;

    localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int WORD_W = KEY_W + SECTOR_W;

    // Request held for the whole sweep.
    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SECTOR_W-1:0] sector_reg;

    logic [WORD_W-1:0]     mem_reg [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;
    logic              cmp_en_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;

    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [SECTOR_W-1:0] hit_sector_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [SECTOR_W-1:0] out_sector_reg;

    logic                match;
    logic                is_free;
    logic                wr_en;
    logic                clr_en;
    logic [STATUS_W-1:0] res_status;
    logic [IDX_W-1:0]    res_idx;
    logic [SECTOR_W-1:0] res_sector;
    logic [IDX_W+INDEX_W-1:0] res_idx_ext;

    assign match   = cmp_en_reg && rd_valid_reg && (rd_word_reg[KEY_W-1:0] == key_reg);
    assign is_free = cmp_en_reg && !rd_valid_reg;

    assign stat.scan_last = (cnt_reg == IDX_W'(TABLE_SIZE - 1));
    assign stat.out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        res_status = STATUS_NOT_FOUND;
        res_idx    = '0;
        res_sector = '0;
        wr_en      = 1'b0;
        clr_en     = 1'b0;
        case (mode_reg)
            MODE_FIND:
            begin
                if (hit_found_reg)
                begin
                    res_status = STATUS_DONE;
                    res_idx    = hit_idx_reg;
                    res_sector = hit_sector_reg;
                end
            end
            MODE_ADD:
            begin
                if (hit_found_reg)
                begin
                    res_status = STATUS_PRESENT;
                end
                else if (free_found_reg)
                begin
                    res_status = STATUS_DONE;
                    res_idx    = free_idx_reg;
                    wr_en      = cmd.commit;
                end
                else
                begin
                    res_status = STATUS_FULL;
                end
            end
            MODE_REMOVE:
            begin
                if (hit_found_reg)
                begin
                    res_status = STATUS_DONE;
                    res_idx    = hit_idx_reg;
                    clr_en     = cmd.commit;
                end
            end
            default:
            begin
                res_status = STATUS_NOT_FOUND;
            end
        endcase
    end

    // Only the low bits of the entry number are reported.
    assign res_idx_ext = {{INDEX_W{1'b0}}, res_idx};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= s_axis_tuser;
            key_reg    <= normalize_key(s_axis_tdata[63:0], s_axis_tdata[71:64], NAME_BYTES);
            sector_reg <= s_axis_tdata[KEY_W +: SECTOR_W];
        end
        if (cmd.scan)
        begin
            rd_word_reg <= mem_reg[cnt_reg];
        end
        if (wr_en)
        begin
            mem_reg[free_idx_reg] <= {sector_reg, key_reg};
        end
        if (match && !hit_found_reg)
        begin
            hit_idx_reg    <= cmp_idx_reg;
            hit_sector_reg <= rd_word_reg[WORD_W-1:KEY_W];
        end
        if (is_free && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.commit)
        begin
            out_status_reg <= res_status;
            out_index_reg  <= res_idx_ext[INDEX_W-1:0];
            out_sector_reg <= res_sector;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            cmp_en_reg     <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            else if (clr_en)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end

            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan && !stat.scan_last)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            cmp_en_reg <= cmd.scan;
            if (cmd.scan)
            begin
                rd_valid_reg <= valid_reg[cnt_reg];
                cmp_idx_reg  <= cnt_reg;
            end

            if (cmd.load)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (match)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (is_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - INDEX_W - SECTOR_W){1'b0}},
                            out_sector_reg, out_index_reg};

endmodule

`default_nettype wire

/* src/nkdt_checker.sv */
// Port-level checker for the directory table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nkdt_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire [nkdt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input wire [nkdt_pkg::MODE_W-1:0]       s_axis_tuser,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [nkdt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire [nkdt_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import nkdt_pkg::*;

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A failed request reports entry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STATUS_DONE) |-> (m_axis_tdata[INDEX_W-1:0] == '0))
        else $error("failed request reports a nonzero entry");

    // A nonzero sector only comes with a successful request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[INDEX_W +: SECTOR_W] != '0) |->
            (m_axis_tuser == STATUS_DONE))
        else $error("sector reported on a failed request");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted during a sweep");

    // No result can appear in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared before the sweep");

endmodule

bind name_keyed_directory_table_unit nkdt_checker u_nkdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
